[hdl/pom_pkg.sv]
// Shared constants, types and the sequencer state encoding for the oscillator mixer.
package pom_pkg;

  localparam int NUM_KEYS        = 16;
  localparam int VOICES_PER_KEY  = 4;
  localparam int MAX_ACTIVE_KEYS = 8;
  localparam int PHASE_BITS      = 24;

  localparam int MASK_W   = 16;
  localparam int INDEX_W  = 4;
  localparam int FREQ_W   = 24;
  localparam int PERIOD_W = 32;
  localparam int GAIN_W   = 16;
  localparam int VC_W     = 3;
  localparam int SAMPLE_W = 19;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // Stream payload layout
  localparam int MASK_LSB  = 0;
  localparam int INDEX_LSB = MASK_LSB + MASK_W;
  localparam int FREQ_LSB  = INDEX_LSB + INDEX_W;
  localparam int S_TDATA_W = ((FREQ_LSB + FREQ_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

  localparam int NUM_SLOTS = NUM_KEYS * VOICES_PER_KEY;
  localparam int KEY_W     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int NV_W      = $clog2(VOICES_PER_KEY + 1);
  localparam int PLAY_W    = $clog2(MAX_ACTIVE_KEYS + 1);

  // Frequency is 16.8 and period 0.32, so the product carries 40 fraction bits
  localparam int PROD_W      = FREQ_W + PERIOD_W;
  localparam int PHASE_SHIFT = 40 - PHASE_BITS;

  // Voice values are 0.16 with 1.0 reachable
  localparam int VAL_W = 17;
  localparam logic [VAL_W-1:0] VOICE_ONE = VAL_W'(65536);

  localparam int ACC_W     = $clog2(VOICES_PER_KEY * 65536 + 1);
  localparam int QUO_W     = VAL_W;
  localparam int MIX_W     = $clog2(MAX_ACTIVE_KEYS * 65536 + 1);
  localparam int DIV_SHIFT = ACC_W + NV_W;
  localparam int RECIP_W   = DIV_SHIFT + 1;

  localparam logic [1:0] REG_WAVE_SELECT = 2'd0;
  localparam logic [1:0] REG_VOICE_COUNT = 2'd1;
  localparam logic [1:0] REG_OUTPUT_GAIN = 2'd2;
  localparam logic [1:0] REG_TICK_PERIOD = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREQ,
    ST_VOICE,
    ST_DRAIN,
    ST_AVG,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic             key_valid;
    logic [ACC_W-1:0] key_sum;
    logic [NV_W-1:0]  nv;
    logic             finish;
  } mix_ctl_t;

endpackage

[hdl/pom_ram.sv]
// Synchronous RAM with one write and one registered read port; unwritten entries read as zero.
module pom_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule

[hdl/pom_mix.sv]
// Per-key voice averaging, key mix accumulation and output gain with saturation.
module pom_mix (
  input  logic                            clk,
  input  logic                            rst,
  input  pom_pkg::mix_ctl_t               ctl,
  input  logic [pom_pkg::GAIN_W-1:0]      gain,
  output logic [pom_pkg::SAMPLE_W-1:0]    sample,
  output logic                            sample_valid
);
  import pom_pkg::*;

  localparam int NV_DEPTH = 2 ** NV_W;

  logic [RECIP_W-1:0]       recip_tab [NV_DEPTH];
  logic [ACC_W+RECIP_W-1:0] qprod;
  logic                     qvalid;
  logic [MIX_W-1:0]         mix;
  logic [MIX_W+GAIN_W-1:0]  gprod;
  logic [MIX_W-1:0]         scaled;

  // Reciprocals rounded up; exact for every sum below 2^ACC_W
  for (genvar d = 0; d < NV_DEPTH; d++) begin : g_recip
    localparam logic [63:0] RECIP =
      ((64'd1 << DIV_SHIFT) + 64'(d) - 64'd1) / ((d == 0) ? 64'd1 : 64'(d));
    assign recip_tab[d] = (d == 0) ? '0 : RECIP[RECIP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid       <= 1'b0;
      sample_valid <= 1'b0;
    end else begin
      qvalid       <= ctl.key_valid;
      sample_valid <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.key_valid) begin
      qprod <= ctl.key_sum * recip_tab[ctl.nv];
    end
    if (ctl.start) begin
      mix <= '0;
    end else if (qvalid) begin
      mix <= mix + MIX_W'(qprod[DIV_SHIFT +: QUO_W]);
    end
    if (ctl.finish) begin
      gprod <= mix * gain;
    end
  end

  assign scaled = gprod[GAIN_W +: MIX_W];
  assign sample = (scaled > MIX_W'(SAMPLE_MAX)) ? SAMPLE_MAX : scaled[SAMPLE_W-1:0];

endmodule

[hdl/pom_seq.sv]
// Key scan and voice sequencer: reads, advances and writes back voice phases in memory.
module pom_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [pom_pkg::MASK_W-1:0]     in_mask,
  input  logic [pom_pkg::INDEX_W-1:0]    in_index,
  input  logic [pom_pkg::FREQ_W-1:0]     in_freq,
  input  logic                           wave_select,
  input  logic [pom_pkg::VC_W-1:0]       voice_count,
  input  logic [pom_pkg::PERIOD_W-1:0]   tick_period,
  input  logic                           out_free,
  output pom_pkg::mix_ctl_t              mix_ctl
);
  import pom_pkg::*;

  seq_state_t state, state_next;

  logic                  accept;
  logic                  tick_start;
  logic                  scan_done;
  logic [NUM_KEYS-1:0]   rem_mask;
  logic [PLAY_W-1:0]     played;
  logic [KEY_W-1:0]      key;
  logic [KEY_W-1:0]      key_pick;
  logic [NV_W-1:0]       v;
  logic [NV_W-1:0]       nv;
  logic [NV_W-1:0]       nv_eff;
  logic [PROD_W-1:0]     prod;
  logic [PHASE_BITS-1:0] inc;
  logic                  rd_pend;
  logic [SLOT_W-1:0]     rd_slot;
  logic [SLOT_W-1:0]     wr_slot;
  logic [ACC_W-1:0]      acc;
  logic                  freq_we;
  logic [FREQ_W-1:0]     freq_rdata;
  logic [PHASE_BITS-1:0] phase_rdata;
  logic [PHASE_BITS-1:0] phase_next;
  logic [PHASE_BITS+15:0] phase_wide;
  logic [15:0]           saw;
  logic [VAL_W-1:0]      value;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign tick_start = accept && !in_func;
  assign freq_we    = accept && in_func && (int'(in_index) < NUM_KEYS);
  assign scan_done  = (rem_mask == '0) || (played == PLAY_W'(MAX_ACTIVE_KEYS));

  always_comb begin
    if (voice_count == '0) begin
      nv_eff = NV_W'(1);
    end else if (int'(voice_count) > VOICES_PER_KEY) begin
      nv_eff = NV_W'(VOICES_PER_KEY);
    end else begin
      nv_eff = NV_W'(voice_count);
    end
  end

  // Lowest pressed key still waiting
  always_comb begin
    key_pick = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (rem_mask[i]) begin
        key_pick = KEY_W'(i);
      end
    end
  end

  assign rd_slot    = SLOT_W'(int'(key) * VOICES_PER_KEY + int'(v));
  assign inc        = prod[PHASE_SHIFT +: PHASE_BITS];
  assign phase_next = phase_rdata + inc;
  assign phase_wide = {phase_next, 16'b0};
  assign saw        = phase_wide[PHASE_BITS+15 -: 16];
  assign value      = wave_select ? (phase_next[PHASE_BITS-1] ? VOICE_ONE : '0)
                                  : VAL_W'(saw);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (tick_start) state_next = ST_SCAN;
      ST_SCAN:   state_next = scan_done ? ST_FINISH : ST_FREQ;
      ST_FREQ:   state_next = ST_VOICE;
      ST_VOICE:  if (v == NV_W'(nv - 1'b1)) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_AVG;
      ST_AVG:    state_next = ST_SCAN;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_VOICE);
    end
  end

  always_ff @(posedge clk) begin
    if (tick_start) begin
      rem_mask <= NUM_KEYS'(in_mask);
      played   <= '0;
      nv       <= nv_eff;
    end
    if (state == ST_SCAN && !scan_done) begin
      key                <= key_pick;
      rem_mask[key_pick] <= 1'b0;
      played             <= played + 1'b1;
      v                  <= '0;
      acc                <= '0;
    end
    if (state == ST_FREQ) begin
      prod <= freq_rdata * tick_period;
    end
    if (state == ST_VOICE) begin
      v <= v + 1'b1;
    end
    wr_slot <= rd_slot;
    if (rd_pend) begin
      acc <= acc + ACC_W'(value);
    end
  end

  pom_ram #(
    .DEPTH (NUM_KEYS),
    .WIDTH (FREQ_W)
  ) u_freq_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (freq_we),
    .waddr (KEY_W'(in_index)),
    .wdata (in_freq),
    .raddr (key_pick),
    .rdata (freq_rdata)
  );

  // Each voice slot is read once and written back in the following cycle, never reread in the tick
  pom_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (PHASE_BITS)
  ) u_phase_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (rd_pend),
    .waddr (wr_slot),
    .wdata (phase_next),
    .raddr (rd_slot),
    .rdata (phase_rdata)
  );

  assign mix_ctl.start     = tick_start;
  assign mix_ctl.key_valid = (state == ST_AVG);
  assign mix_ctl.key_sum   = acc;
  assign mix_ctl.nv        = nv;
  assign mix_ctl.finish    = (state == ST_FINISH) && out_free;

endmodule

[hdl/polyphonic_oscillator_mixer_core.sv]
// Top level of the polyphonic oscillator bank and mixer: config registers and output stage.
//
// A table-write item (tuser = 1) leaves the block ready for the next item. A tick
// item (tuser = 0) walks up to eight played keys, each through N voices, where N is
// the effective voice count (one to four). Its length is set by the voice walk
// through the phase memory, which reads one slot and writes back one slot per
// cycle; each key adds a frequency-table read, an increment multiply and the
// averaging step. The sample passes the gain product register in the mixer and
// then the output register; a tick whose sample finds the output register still
// full holds at the end of its scan until the register drains. Both memories
// reset through per-entry valid bits, so there is no clearing pass after reset.
module polyphonic_oscillator_mixer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pom_pkg::S_TDATA_W-1:0]    s_tdata,  // key_mask, key_index, key_frequency, pad
  input  logic                             s_tuser,  // func
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pom_pkg::M_TDATA_W-1:0]    m_tdata,  // sample, pad
  input  logic                             cfg_wen,
  input  logic [1:0]                       cfg_index,
  input  logic [pom_pkg::PERIOD_W-1:0]     cfg_wdata
);
  import pom_pkg::*;

  logic                wave_select;
  logic [VC_W-1:0]     voice_count;
  logic [GAIN_W-1:0]   output_gain;
  logic [PERIOD_W-1:0] tick_period;
  logic                out_free;
  mix_ctl_t            mix_ctl;
  logic [SAMPLE_W-1:0] sample;
  logic                sample_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select <= 1'b0;
      voice_count <= VC_W'(4);
      output_gain <= GAIN_W'(2621);
      tick_period <= PERIOD_W'(97392);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_WAVE_SELECT: wave_select <= cfg_wdata[0];
        REG_VOICE_COUNT: voice_count <= cfg_wdata[VC_W-1:0];
        REG_OUTPUT_GAIN: output_gain <= cfg_wdata[GAIN_W-1:0];
        REG_TICK_PERIOD: tick_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;

  pom_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_func     (s_tuser),
    .in_mask     (s_tdata[MASK_LSB +: MASK_W]),
    .in_index    (s_tdata[INDEX_LSB +: INDEX_W]),
    .in_freq     (s_tdata[FREQ_LSB +: FREQ_W]),
    .wave_select (wave_select),
    .voice_count (voice_count),
    .tick_period (tick_period),
    .out_free    (out_free),
    .mix_ctl     (mix_ctl)
  );

  pom_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .ctl          (mix_ctl),
    .gain         (output_gain),
    .sample       (sample),
    .sample_valid (sample_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sample_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid) begin
      m_tdata <= M_TDATA_W'(sample);
    end
  end

  // A new sample never lands on an item still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> !m_tvalid)
    else $error("sample arrived while output register held an item");

  a_finish_gives_sample: assert property (@(posedge clk) disable iff (rst)
    mix_ctl.finish |=> sample_valid)
    else $error("finished tick produced no sample");

  a_write_stays_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> s_tready)
    else $error("table write item left the block busy");

endmodule

[sim/tb_top.sv]
// Self-checking bench for the oscillator bank mixer: random ticks and table writes across settings.
module tb_top;
  import pom_pkg::*;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;
  localparam int   SETTLE     = 80;
  localparam int   LIMIT      = 1000000;
  localparam int   PHASES     = 8;
  localparam int   PHASE_ITEMS = 92;

  typedef struct packed {
    logic               func;
    logic [MASK_W-1:0]  mask;
    logic [INDEX_W-1:0] index;
    logic [FREQ_W-1:0]  freq;
  } osc_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_wen = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [PERIOD_W-1:0]  cfg_wdata = '0;

  polyphonic_oscillator_mixer_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Mirror of the oscillator state and settings
  logic [PHASE_BITS-1:0] voice_ph [NUM_SLOTS];
  logic [FREQ_W-1:0]     key_freq [NUM_KEYS];
  logic                  wave_sel = 1'b0;
  logic [VC_W-1:0]       voice_cnt = 3'd4;
  logic [GAIN_W-1:0]     gain = 16'd2621;
  logic [PERIOD_W-1:0]   period = 32'd97392;

  osc_item_t             stim_q [$];
  logic [SAMPLE_W-1:0]   sample_q [$];
  osc_item_t             cur_item;
  int                    errors = 0;
  int                    in_gap = 0;
  int                    out_stall = 0;
  int                    cycle_cnt = 0;
  bit                    idle_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) voice_ph[i] = '0;
    for (int i = 0; i < NUM_KEYS; i++) key_freq[i] = '0;
  end

  task automatic report(input string msg);
    if (errors < 100) $display("mismatch @%0d: %s", cycle_cnt, msg);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [16:0] wave_value(input logic [PHASE_BITS-1:0] ph);
    if (wave_sel) return ph[PHASE_BITS-1] ? 17'd65536 : 17'd0;
    return 17'(ph >> (PHASE_BITS - 16));
  endfunction

  // Apply one accepted item to the mirror; ticks queue their sample
  function automatic void mix_item(input osc_item_t it);
    int unsigned nv;
    int unsigned played;
    int unsigned slot;
    logic [63:0] inc;
    logic [63:0] acc;
    logic [63:0] mix;
    logic [63:0] scaled;
    if (it.func == FUNC_WRITE) begin
      if (it.index < NUM_KEYS) key_freq[it.index] = it.freq;
      return;
    end
    nv = voice_cnt;
    if (nv < 1) nv = 1;
    if (nv > VOICES_PER_KEY) nv = VOICES_PER_KEY;
    played = 0;
    mix = '0;
    for (int k = 0; k < NUM_KEYS && k < MASK_W; k++) begin
      if (!it.mask[k] || played >= MAX_ACTIVE_KEYS) continue;
      played++;
      inc = (64'(key_freq[k]) * 64'(period)) >> PHASE_SHIFT;
      acc = '0;
      for (int v = 0; v < nv; v++) begin
        slot = k * VOICES_PER_KEY + v;
        voice_ph[slot] = voice_ph[slot] + inc[PHASE_BITS-1:0];
        acc += 64'(wave_value(voice_ph[slot]));
      end
      mix += acc / nv;
    end
    scaled = (mix * 64'(gain)) >> 16;
    if (scaled > 64'(SAMPLE_MAX)) scaled = 64'(SAMPLE_MAX);
    sample_q.push_back(scaled[SAMPLE_W-1:0]);
  endfunction

  // Input driver: present items from the queue, with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) mix_item(cur_item);
      if (!s_tvalid || s_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur_item = stim_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cur_item.func;
          s_tdata  <= S_TDATA_W'({cur_item.freq, cur_item.index, cur_item.mask});
          in_gap = gap_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random backpressure, compare each sample with the oldest expected one
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (sample_q.size() == 0) begin
          report($sformatf("unexpected sample %0d", m_tdata[SAMPLE_W-1:0]));
        end else begin
          if (m_tdata[SAMPLE_W-1:0] !== sample_q[0])
            report($sformatf("sample got %0d exp %0d", m_tdata[SAMPLE_W-1:0], sample_q[0]));
          void'(sample_q.pop_front());
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic set_reg(input logic [1:0] idx, input logic [PERIOD_W-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_WAVE_SELECT: wave_sel  = val[0];
      REG_VOICE_COUNT: voice_cnt = val[VC_W-1:0];
      REG_OUTPUT_GAIN: gain      = val[GAIN_W-1:0];
      REG_TICK_PERIOD: period    = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (stim_q.size() != 0 || s_tvalid || sample_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic osc_item_t make_tick(input logic [MASK_W-1:0] mask);
    osc_item_t it;
    it.func  = FUNC_TICK;
    it.mask  = mask;
    it.index = INDEX_W'($urandom);
    it.freq  = FREQ_W'($urandom);
    return it;
  endfunction

  function automatic osc_item_t make_write(input int idx, input logic [FREQ_W-1:0] freq);
    osc_item_t it;
    it.func  = FUNC_WRITE;
    it.mask  = MASK_W'($urandom);
    it.index = INDEX_W'(idx);
    it.freq  = freq;
    return it;
  endfunction

  function automatic osc_item_t rand_item();
    int r;
    logic [MASK_W-1:0] m;
    logic [FREQ_W-1:0] f;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      if ($urandom_range(0, 2) == 0) f = FREQ_W'($urandom);
      else f = FREQ_W'($urandom_range(0, 5000 << 8));
      return make_write($urandom_range(0, NUM_KEYS - 1), f);
    end
    r = $urandom_range(0, 9);
    case (r)
      0: m = '0;
      1: m = '1;
      2, 3: m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      4, 5: m = (MASK_W'(1) << $urandom_range(0, MASK_W - 1))
              | (MASK_W'(1) << $urandom_range(0, MASK_W - 1))
              | (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
      default: m = MASK_W'($urandom);
    endcase
    return make_tick(m);
  endfunction

  initial begin
    logic [PERIOD_W-1:0] p_val;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty table, then edge frequencies and masks past the key limit
    stim_q.push_back(make_tick('0));
    stim_q.push_back(make_tick('1));
    stim_q.push_back(make_write(0, '1));
    stim_q.push_back(make_write(15, '0));
    stim_q.push_back(make_write(1, 24'h01B800));
    stim_q.push_back(make_write(7, 24'h000001));
    stim_q.push_back(make_write(8, 24'h800000));
    stim_q.push_back(make_write(9, 24'h7FFFFF));
    for (int k = 2; k <= 6; k++) stim_q.push_back(make_write(k, FREQ_W'($urandom)));
    stim_q.push_back(make_tick(16'h0001));
    stim_q.push_back(make_tick(16'h0002));
    stim_q.push_back(make_tick(16'h8001));
    stim_q.push_back(make_tick(16'hFFFF));
    stim_q.push_back(make_tick(16'hFF00));
    stim_q.push_back(make_tick(16'h00FF));
    stim_q.push_back(make_tick(16'hAAAA));
    stim_q.push_back(make_tick(16'h5555));
    stim_q.push_back(make_tick(16'hFFFF));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          set_reg(REG_WAVE_SELECT, 32'd1);
          set_reg(REG_VOICE_COUNT, 32'd4);
          set_reg(REG_OUTPUT_GAIN, 32'hFFFF);
          set_reg(REG_TICK_PERIOD, 32'hFFFF_FFFF);
        end
        1: begin
          set_reg(REG_WAVE_SELECT, 32'd0);
          set_reg(REG_VOICE_COUNT, 32'd0);
          set_reg(REG_OUTPUT_GAIN, 32'd0);
          set_reg(REG_TICK_PERIOD, 32'd0);
        end
        2: begin
          set_reg(REG_WAVE_SELECT, 32'd1);
          set_reg(REG_VOICE_COUNT, 32'd7);
          set_reg(REG_OUTPUT_GAIN, 32'd2621);
          set_reg(REG_TICK_PERIOD, 32'd97392);
        end
        3: begin
          set_reg(REG_WAVE_SELECT, 32'd0);
          set_reg(REG_VOICE_COUNT, 32'd1);
          set_reg(REG_OUTPUT_GAIN, 32'hFFFF);
          set_reg(REG_TICK_PERIOD, 32'h8000_0000);
        end
        default: begin
          if ($urandom_range(0, 1)) p_val = $urandom;
          else p_val = $urandom_range(0, 32'h0010_0000);
          set_reg(REG_WAVE_SELECT, 32'($urandom_range(0, 1)));
          set_reg(REG_VOICE_COUNT, 32'($urandom_range(0, 7)));
          set_reg(REG_OUTPUT_GAIN, 32'($urandom_range(0, 65535)));
          set_reg(REG_TICK_PERIOD, p_val);
        end
      endcase
      @(posedge clk);
      cfg_wen <= 1'b0;
      // One phase runs both sides at full rate
      idle_on = (p != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) stim_q.push_back(rand_item());
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/pom_pkg.sv
hdl/pom_ram.sv
hdl/pom_mix.sv
hdl/pom_seq.sv
hdl/polyphonic_oscillator_mixer_core.sv
sim/tb_top.sv
